### rtl/polynomial_extremum_bisection_core_defines.svh
// assertion macros for the polynomial extremum bisection core
// needs a clock named clk and a synchronous reset named rst in the using module
`ifndef POLYNOMIAL_EXTREMUM_BISECTION_CORE_DEFINES_SVH
`define POLYNOMIAL_EXTREMUM_BISECTION_CORE_DEFINES_SVH

// checked only outside reset
`define PEB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define PEB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/peb_pkg.sv
// types and constants shared by the bisection controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package peb_pkg;

  localparam int NUM_COEFFS  = 7;
  localparam int CIDX_W      = 3;
  localparam int ITER_W      = 7;

  localparam logic [CIDX_W-1:0] REG_TOLERANCE = 3'd7;
  localparam logic [30:0]       TOL_RESET     = 31'd66;
  localparam logic [63:0]       SAT_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_MUL,
    S_COMB,
    S_ADD,
    S_POST,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    K_LO,
    K_HI,
    K_MID
  } kind_t;

  typedef enum logic [1:0] {
    STAT_FOUND     = 2'd0,
    STAT_NO_CHANGE = 2'd1,
    STAT_NOT_CONV  = 2'd2
  } status_t;

  typedef struct packed {
    logic              load;
    logic              init;
    kind_t             kind;
    logic              mul;
    logic              comb;
    logic              add;
    logic [CIDX_W-1:0] cidx;
    logic              save_dlo;
    logic              step;
    logic              out_load;
    logic              out_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic same_sign;
    logic above_tol;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/peb_datapath.sv
// datapath: coefficient and tolerance registers, bounds, horner derivative unit
// depends on peb_pkg
`timescale 1ns / 1ps
`default_nettype none

module peb_datapath #(
  parameter int MAX_DEGREE    = 6,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [peb_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [31:0]               cfg_data,
  input  wire logic [63:0]               in_data,
  input  wire peb_pkg::dp_cmd_t          cmd,
  output peb_pkg::dp_stat_t              stat,
  output logic [31:0]                    position
);
  import peb_pkg::*;

  localparam int          SHIFT_UP = 32 - FRACTION_BITS;
  localparam logic [63:0] HI_LIM   = SAT_MAX >> SHIFT_UP;

  logic signed [31:0] coeff [NUM_COEFFS];
  logic [30:0]        tol;

  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic signed [31:0] x;
  logic signed [63:0] der;
  logic signed [63:0] val;
  logic               dlo_neg;
  logic               dlo_zero;

  logic [63:0]        pd_lo;
  logic [63:0]        pd_hi;
  logic [63:0]        pv_lo;
  logic [63:0]        pv_hi;
  logic               neg_d;
  logic               neg_v;
  logic signed [63:0] fd;
  logic signed [63:0] fv;

  logic signed [32:0] msum;
  logic signed [31:0] mid;
  logic [63:0]        md;
  logic [63:0]        mv;
  logic [31:0]        nx;
  logic [63:0]        der_mag;
  logic               der_zero;

  function automatic logic signed [63:0] fx_combine(input logic [63:0] ph,
                                                    input logic [63:0] pl,
                                                    input logic        neg);
    logic [63:0] up;
    logic [63:0] sum;
    logic [63:0] r;
    up  = ph << SHIFT_UP;
    sum = up + (pl >> FRACTION_BITS);
    if (ph > HI_LIM || sum[63]) begin
      r = SAT_MAX;
    end else begin
      r = sum;
    end
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [64:0] lim;
    lim = $signed({1'b0, SAT_MAX});
    s   = {a[63], a} + {b[63], b};
    if (s > lim) begin
      return $signed(SAT_MAX);
    end else if (s < -lim) begin
      return -$signed(SAT_MAX);
    end
    return s[63:0];
  endfunction

  assign msum     = {lo[31], lo} + {hi[31], hi};
  assign mid      = msum[32:1];
  assign md       = der[63] ? -der : der;
  assign mv       = val[63] ? -val : val;
  assign nx       = x[31] ? -x : x;
  assign der_mag  = md;
  assign der_zero = (der == 64'sd0);

  assign stat.same_sign = (der_zero == dlo_zero) && (der_zero || (der[63] == dlo_neg));
  assign stat.above_tol = der_mag > {33'd0, tol};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        coeff[i] <= '0;
      end
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TOLERANCE) begin
        tol <= cfg_data[30:0];
      end else begin
        coeff[cfg_index] <= cfg_data;
      end
    end
  end

  // bounds, evaluation point and horner registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo <= in_data[31:0];
      hi <= in_data[63:32];
    end
    if (cmd.init) begin
      case (cmd.kind)
        K_LO:    x <= lo;
        K_HI:    x <= hi;
        default: x <= mid;
      endcase
      val <= 64'(coeff[MAX_DEGREE]);
      der <= '0;
    end
    if (cmd.mul) begin
      pd_lo <= md[31:0] * nx;
      pd_hi <= md[63:32] * nx;
      pv_lo <= mv[31:0] * nx;
      pv_hi <= mv[63:32] * nx;
      neg_d <= der[63] ^ x[31];
      neg_v <= val[63] ^ x[31];
    end
    if (cmd.comb) begin
      fd <= fx_combine(pd_hi, pd_lo, neg_d);
      fv <= fx_combine(pv_hi, pv_lo, neg_v);
    end
    if (cmd.add) begin
      der <= sat_add(fd, val);
      val <= sat_add(fv, 64'(coeff[cmd.cidx]));
    end
    if (cmd.save_dlo) begin
      dlo_neg  <= der[63];
      dlo_zero <= der_zero;
    end
    if (cmd.step) begin
      if (stat.same_sign) begin
        lo       <= x;
        dlo_neg  <= der[63];
        dlo_zero <= der_zero;
      end else begin
        hi <= x;
      end
    end
    if (cmd.out_load) begin
      position <= cmd.out_zero ? 32'd0 : x;
    end
  end

endmodule

`default_nettype wire

### rtl/peb_ctrl.sv
// controller: sequences the horner steps, the end checks and the halvings
// depends on peb_pkg and polynomial_extremum_bisection_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "polynomial_extremum_bisection_core_defines.svh"

module peb_ctrl #(
  parameter int MAX_DEGREE     = 6,
  parameter int MAX_ITERATIONS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output peb_pkg::status_t                out_status,
  output logic [peb_pkg::ITER_W-1:0]      out_iters,
  output peb_pkg::dp_cmd_t                cmd,
  input  wire peb_pkg::dp_stat_t          stat
);
  import peb_pkg::*;

  state_t              state;
  state_t              state_next;
  kind_t               kind;
  kind_t               kind_next;
  logic [CIDX_W-1:0]   cidx;
  logic [CIDX_W-1:0]   cidx_next;
  logic [ITER_W-1:0]   iters;
  logic [ITER_W-1:0]   iters_next;
  status_t             fin_status;
  status_t             fin_status_next;
  logic                out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kind       <= K_LO;
      cidx       <= '0;
      iters      <= '0;
      fin_status <= STAT_FOUND;
      out_valid  <= 1'b0;
      out_status <= STAT_FOUND;
      out_iters  <= '0;
    end else begin
      state      <= state_next;
      kind       <= kind_next;
      cidx       <= cidx_next;
      iters      <= iters_next;
      fin_status <= fin_status_next;
      out_valid  <= out_valid_next;
      if (cmd.out_load) begin
        out_status <= fin_status;
        out_iters  <= iters;
      end
    end
  end

  always_comb begin
    state_next      = state;
    kind_next       = kind;
    cidx_next       = cidx;
    iters_next      = iters;
    fin_status_next = fin_status;
    out_valid_next  = out_valid && !out_ready;
    cmd             = '0;
    cmd.kind        = kind;
    cmd.cidx        = cidx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          kind_next  = K_LO;
          iters_next = '0;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        cidx_next  = CIDX_W'(MAX_DEGREE - 1);
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_COMB;
      end
      S_COMB: begin
        cmd.comb   = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (cidx == '0) begin
          state_next = S_POST;
        end else begin
          cidx_next  = cidx - 1'b1;
          state_next = S_MUL;
        end
      end
      S_POST: begin
        case (kind)
          K_LO: begin
            cmd.save_dlo = 1'b1;
            kind_next    = K_HI;
            state_next   = S_INIT;
          end
          K_HI: begin
            iters_next = '0;
            if (stat.same_sign) begin
              fin_status_next = STAT_NO_CHANGE;
              state_next      = S_FINISH;
            end else begin
              kind_next  = K_MID;
              state_next = S_INIT;
            end
          end
          default: begin
            if (stat.above_tol && iters != ITER_W'(MAX_ITERATIONS)) begin
              cmd.step   = 1'b1;
              iters_next = iters + 1'b1;
              state_next = S_INIT;
            end else begin
              fin_status_next = stat.above_tol ? STAT_NOT_CONV : STAT_FOUND;
              state_next      = S_FINISH;
            end
          end
        endcase
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          cmd.out_zero   = (fin_status == STAT_NO_CHANGE);
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `PEB_ASSERT_RST(a_reset_clears, rst |=> (state == S_IDLE && !out_valid), "reset left state")
  `PEB_ASSERT(a_rise_from_finish, $rose(out_valid) |-> $past(state == S_FINISH), "stray result")
  `PEB_ASSERT(a_nochange_no_iters,
              (out_valid && out_status == STAT_NO_CHANGE) |-> (out_iters == '0),
              "no sign change with halvings")
  `PEB_ASSERT(a_notconv_full_iters,
              (out_valid && out_status == STAT_NOT_CONV) |-> (out_iters == ITER_W'(MAX_ITERATIONS)),
              "not converged before iteration limit")

endmodule

`default_nettype wire

### rtl/polynomial_extremum_bisection_core.sv
// top level of the polynomial extremum bisection core
// depends on peb_pkg, peb_ctrl and peb_datapath
`timescale 1ns / 1ps
`default_nettype none

// Finds a zero of the first derivative of the configured polynomial inside the
// interval carried by one input transaction, by bisection, and returns one result
// transaction: the last midpoint (zero when the ends show no sign change), a status
// (found, no sign change at the ends, not converged) and the number of halvings.
// Coefficients and tolerance are written through the cfg port; the user must do so
// only while the core is idle, as the core itself does not enforce it. Each
// derivative evaluation runs the Horner loop one coefficient at a time through a
// shared multiply, saturate and add path, stepping through its multiply, combine
// and add states for each coefficient. A finished result waits in the output
// register while the next transaction is accepted.
module polynomial_extremum_bisection_core #(
  parameter int MAX_DEGREE     = 6,
  parameter int MAX_ITERATIONS = 64,
  parameter int FRACTION_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // left_bound[31:0], right_bound[63:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // extremum_position[31:0], iterations_used[38:32]
  output logic [1:0]       m_tuser,   // status[1:0]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import peb_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  status_t           out_status;
  logic [ITER_W-1:0] out_iters;
  logic [31:0]       position;

  peb_ctrl #(
    .MAX_DEGREE     (MAX_DEGREE),
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_iters  (out_iters),
    .cmd        (cmd),
    .stat       (stat)
  );

  peb_datapath #(
    .MAX_DEGREE    (MAX_DEGREE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .position  (position)
  );

  assign m_tdata = {1'b0, out_iters, position};
  assign m_tuser = out_status;

endmodule

`default_nettype wire
